// ===== rtl/tslf_pkg.sv =====
// shared types and constants of the text stream line formatter
`default_nettype none

package tslf_pkg;

    // configuration register indexes
    localparam int               CFG_IDX_W          = 3;
    localparam int               CFG_DATA_W         = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINT  = 3'd4;

    // number modes
    localparam logic [1:0] NUM_NONE     = 2'd0;
    localparam logic [1:0] NUM_ALL      = 2'd1;
    localparam logic [1:0] NUM_NONBLANK = 2'd2;

    // blank line run saturation
    localparam logic [1:0] RUN_MAX = 2'd2;

    // character codes
    localparam logic [7:0] CHR_TAB      = 8'd9;
    localparam logic [7:0] CHR_NL       = 8'd10;
    localparam logic [7:0] CHR_SPACE    = 8'd32;
    localparam logic [7:0] CHR_DOLLAR   = 8'd36;
    localparam logic [7:0] CHR_ZERO     = 8'd48;
    localparam logic [7:0] CHR_QMARK    = 8'd63;
    localparam logic [7:0] CHR_CARET    = 8'd94;
    localparam logic [7:0] CHR_DEL      = 8'd127;
    localparam logic [7:0] CARET_OFFSET = 8'd64;
    localparam logic [7:0] CTL_LOW_MAX  = 8'd8;
    localparam logic [7:0] CTL_HIGH_MIN = 8'd11;
    localparam logic [7:0] CTL_HIGH_MAX = 8'd31;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef struct packed {
        logic [1:0] number_mode;
        logic       squeeze_blank;
        logic       show_ends;
        logic       show_tabs;
        logic       show_nonprinting;
    } cfg_t;

    // one queued output command
    typedef struct packed {
        logic       has_num;
        logic       dollar;
        logic       caret;
        logic [7:0] data;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/tslf_front.sv =====
// front end: configuration, line state, line counter and command classification
`default_nettype none

module tslf_front #(
    parameter int NUMBER_DIGITS = 6
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    input  wire logic [tslf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tslf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           kind,
    input  wire logic [7:0]                     byte_value,
    input  wire logic                           q_full,
    output logic                                push,
    output tslf_pkg::cmd_t                      cmd,
    output logic [4*NUMBER_DIGITS-1:0]          num,
    output logic [NUMBER_DIGITS-1:0]            blank
);

    localparam int CW = 4 * NUMBER_DIGITS;

    tslf_pkg::cfg_t  cfg_reg;
    logic [CW-1:0]   count_reg, count_next, count_inc;
    logic            als_reg, als_next;
    logic [1:0]      run_reg, run_next, run_inc;
    logic            acc, is_nl, is_ctl, caret, numbering, all_nines;
    logic [NUMBER_DIGITS:0] carry;
    logic            zero_run;

    assign in_ready = !q_full;
    assign acc      = in_valid && in_ready;
    assign is_nl    = (byte_value == tslf_pkg::CHR_NL);
    assign run_inc  = (run_reg == tslf_pkg::RUN_MAX) ? run_reg : run_reg + 2'd1;
    assign is_ctl   = (byte_value <= tslf_pkg::CTL_LOW_MAX)
                    || ((byte_value >= tslf_pkg::CTL_HIGH_MIN)
                        && (byte_value <= tslf_pkg::CTL_HIGH_MAX))
                    || (byte_value == tslf_pkg::CHR_DEL);
    assign caret    = ((byte_value == tslf_pkg::CHR_TAB) && cfg_reg.show_tabs)
                    || (cfg_reg.show_nonprinting && is_ctl);

    // bcd increment with ripple carry
    always_comb
    begin
        carry[0] = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            if (carry[i])
            begin
                count_inc[4*i +: 4] = (count_reg[4*i +: 4] == 4'd9) ? 4'd0
                                    : count_reg[4*i +: 4] + 4'd1;
            end
            else
            begin
                count_inc[4*i +: 4] = count_reg[4*i +: 4];
            end
            carry[i+1] = carry[i] && (count_reg[4*i +: 4] == 4'd9);
        end
    end
    assign all_nines = carry[NUMBER_DIGITS];

    // leading digit blanking
    always_comb
    begin
        zero_run = 1'b1;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--)
        begin
            zero_run = zero_run && (count_reg[4*i +: 4] == 4'd0);
            blank[i] = zero_run && (i != 0);
        end
    end
    assign num = count_reg;

    always_comb
    begin
        als_next   = als_reg;
        run_next   = run_reg;
        count_next = count_reg;
        push       = 1'b0;
        numbering  = 1'b0;
        cmd        = '0;
        if (acc)
        begin
            if (kind)
            begin
                als_next = 1'b1;
                run_next = 2'd0;
            end
            else if (is_nl)
            begin
                push       = 1'b1;
                cmd.dollar = cfg_reg.show_ends;
                cmd.data   = tslf_pkg::CHR_NL;
                als_next   = 1'b1;
                if (als_reg)
                begin
                    run_next = run_inc;
                    if (cfg_reg.squeeze_blank && (run_inc == tslf_pkg::RUN_MAX))
                    begin
                        push = 1'b0;
                    end
                    else
                    begin
                        numbering = (cfg_reg.number_mode == tslf_pkg::NUM_ALL);
                    end
                end
            end
            else
            begin
                push      = 1'b1;
                numbering = als_reg && ((cfg_reg.number_mode == tslf_pkg::NUM_ALL)
                                     || (cfg_reg.number_mode == tslf_pkg::NUM_NONBLANK));
                cmd.caret = caret;
                if (caret)
                begin
                    cmd.data = (byte_value == tslf_pkg::CHR_DEL) ? tslf_pkg::CHR_QMARK
                             : byte_value + tslf_pkg::CARET_OFFSET;
                end
                else
                begin
                    cmd.data = byte_value;
                end
                als_next = 1'b0;
                run_next = 2'd0;
            end
        end
        cmd.has_num = numbering;
        if (numbering && !all_nines)
        begin
            count_next = count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= '{number_mode: tslf_pkg::NUM_NONE, default: 1'b0};
            count_reg <= {{(CW-4){1'b0}}, 4'd1};
            als_reg   <= 1'b1;
            run_reg   <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            als_reg   <= als_next;
            run_reg   <= run_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    tslf_pkg::CFG_NUMBER_MODE:   cfg_reg.number_mode      <= cfg_data;
                    tslf_pkg::CFG_SQUEEZE_BLANK: cfg_reg.squeeze_blank    <= cfg_data[0];
                    tslf_pkg::CFG_SHOW_ENDS:     cfg_reg.show_ends        <= cfg_data[0];
                    tslf_pkg::CFG_SHOW_TABS:     cfg_reg.show_tabs        <= cfg_data[0];
                    tslf_pkg::CFG_SHOW_NONPRINT: cfg_reg.show_nonprinting <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tslf_queue.sv =====
// command queue between front end and output sequencer
`default_nettype none

module tslf_queue #(
    parameter int NUMBER_DIGITS = 6
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  wire tslf_pkg::cmd_t                 push_cmd,
    input  wire logic [4*NUMBER_DIGITS-1:0]     push_num,
    input  wire logic [NUMBER_DIGITS-1:0]       push_blank,
    input  wire logic                           pop,
    output logic                                full,
    output logic                                head_valid,
    output tslf_pkg::cmd_t                      head_cmd,
    output logic [4*NUMBER_DIGITS-1:0]          head_num,
    output logic [NUMBER_DIGITS-1:0]            head_blank
);

    tslf_pkg::cmd_t                 cmd_mem   [tslf_pkg::QUEUE_DEPTH];
    logic [4*NUMBER_DIGITS-1:0]     num_mem   [tslf_pkg::QUEUE_DEPTH];
    logic [NUMBER_DIGITS-1:0]       blank_mem [tslf_pkg::QUEUE_DEPTH];
    logic [tslf_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [tslf_pkg::QUEUE_CNT_W-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == tslf_pkg::QUEUE_CNT_W'(tslf_pkg::QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = cmd_mem[rd_ptr_reg];
    assign head_num   = num_mem[rd_ptr_reg];
    assign head_blank = blank_mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_mem[wr_ptr_reg]   <= push_cmd;
            num_mem[wr_ptr_reg]   <= push_num;
            blank_mem[wr_ptr_reg] <= push_blank;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tslf_back.sv =====
// output sequencer: expands one command into bytes, one per cycle while the output is not stalled
`default_nettype none

module tslf_back #(
    parameter int NUMBER_DIGITS = 6
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           head_valid,
    input  wire tslf_pkg::cmd_t                 head_cmd,
    input  wire logic [4*NUMBER_DIGITS-1:0]     head_num,
    input  wire logic [NUMBER_DIGITS-1:0]       head_blank,
    output logic                                pop,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [7:0]                          out_byte,
    output logic                                out_last
);

    localparam int STW = $clog2(NUMBER_DIGITS + 3);
    localparam int DW  = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
    localparam logic [STW-1:0] ST_TAB  = STW'(NUMBER_DIGITS);
    localparam logic [STW-1:0] ST_MARK = STW'(NUMBER_DIGITS + 1);
    localparam logic [STW-1:0] ST_DATA = STW'(NUMBER_DIGITS + 2);

    logic [STW-1:0] st_reg, cur_st, start_st, nxt_st, after_tab;
    logic           busy_reg;
    logic           out_valid_reg, out_last_reg;
    logic [7:0]     out_byte_reg;
    logic [7:0]     digit_chr [NUMBER_DIGITS];
    logic [DW-1:0]  idx;
    logic [7:0]     cur_byte;
    logic           is_last, out_free, fire;

    always_comb
    begin
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            digit_chr[i] = head_blank[i] ? tslf_pkg::CHR_SPACE
                         : tslf_pkg::CHR_ZERO + {4'd0, head_num[4*i +: 4]};
        end
    end

    assign after_tab = (head_cmd.dollar || head_cmd.caret) ? ST_MARK : ST_DATA;
    assign start_st  = head_cmd.has_num ? '0 : after_tab;
    assign cur_st    = busy_reg ? st_reg : start_st;
    assign nxt_st    = (cur_st == ST_TAB) ? after_tab : cur_st + 1'b1;
    assign idx       = DW'(NUMBER_DIGITS - 1) - cur_st[DW-1:0];
    assign is_last   = (cur_st == ST_DATA);

    always_comb
    begin
        if (cur_st < ST_TAB)
        begin
            cur_byte = digit_chr[idx];
        end
        else if (cur_st == ST_TAB)
        begin
            cur_byte = tslf_pkg::CHR_TAB;
        end
        else if (cur_st == ST_MARK)
        begin
            cur_byte = head_cmd.dollar ? tslf_pkg::CHR_DOLLAR : tslf_pkg::CHR_CARET;
        end
        else
        begin
            cur_byte = head_cmd.data;
        end
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign fire      = head_valid && out_free;
    assign pop       = fire && is_last;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= head_valid;
            end
            if (fire)
            begin
                busy_reg <= !is_last;
                st_reg   <= nxt_st;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= is_last;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/text_stream_line_formatter_core.sv =====
// Text stream line formatter top level: a front end classifies input bytes and keeps the
// line state and BCD line counter, a four-entry command queue decouples it from an output
// sequencer that emits one formatted byte per cycle while the sink accepts. A plain byte
// yields one output byte; a byte that opens a numbered line yields NUMBER_DIGITS + 2 bytes
// (digits, tab, byte), and a caret pair or a '$' before newline adds one byte. File-start
// marks and squeezed blank lines produce no output transaction and are consumed by the
// front end alone. Input is taken whenever the queue has room, also while an output
// transaction is stalled. Configuration writes are always accepted and should be issued
// only while the block is idle.
`default_nettype none

module text_stream_line_formatter_core #(
    parameter int NUMBER_DIGITS = 6
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tslf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tslf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // byte_value
    input  wire logic                           s_tuser,   // kind
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [7:0]                          m_tdata,   // out_byte
    output logic                                m_tlast
);

    logic                       push, pop, q_full, head_valid;
    tslf_pkg::cmd_t             push_cmd, head_cmd;
    logic [4*NUMBER_DIGITS-1:0] push_num, head_num;
    logic [NUMBER_DIGITS-1:0]   push_blank, head_blank;

    assign cfg_ready = 1'b1;

    tslf_front #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .kind       (s_tuser),
        .byte_value (s_tdata),
        .q_full     (q_full),
        .push       (push),
        .cmd        (push_cmd),
        .num        (push_num),
        .blank      (push_blank)
    );

    tslf_queue #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_num   (push_num),
        .push_blank (push_blank),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .head_num   (head_num),
        .head_blank (head_blank)
    );

    tslf_back #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .head_num   (head_num),
        .head_blank (head_blank),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/tslf_checker.sv =====
// port-level checks of the text stream line formatter and their binding
`default_nettype none

module tslf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output transaction changed while stalled");

    // a caret prefix is followed at once by its final byte
    a_caret_pair: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast && (m_tdata == tslf_pkg::CHR_CARET)
        |=> m_tvalid && m_tlast)
        else $error("caret prefix not followed by its byte");

    // a line end mark is followed at once by the newline
    a_dollar_nl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast && (m_tdata == tslf_pkg::CHR_DOLLAR)
        |=> m_tvalid && m_tlast && (m_tdata == tslf_pkg::CHR_NL))
        else $error("line end mark not followed by newline");

endmodule

bind text_stream_line_formatter_core tslf_checker u_tslf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== bench/text_stream_line_formatter_core_tb.sv =====
// self-checking testbench of the text stream line formatter core with a built-in predictor
`default_nettype none

module text_stream_line_formatter_core_tb;

    localparam int NUMBER_DIGITS = 6;
    localparam int IDLE_PCT = 24;
    localparam int SETTLE_CYCLES = 24;
    localparam int SINK_HOLD = 400;
    localparam int QUIET_LIMIT = 4000;
    localparam int MAX_SHOWN = 10;
    localparam int PHASE_ITEMS = 95;
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_FILE = 1'b1;
    localparam logic [1:0] NUM_UNUSED = 2'd3;
    localparam logic [tslf_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
    localparam logic [3:0] BCD_NINE = 4'd9;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
    } text_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [tslf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tslf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;     // byte_value
    logic s_tuser = 1'b0;         // kind
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;          // out_byte
    logic m_tlast;

    text_item_t pending_in[$];
    out_beat_t want_out[$];
    logic [7:0] item_beats[$];

    tslf_pkg::cfg_t fmt_cfg = '0;
    logic [4*NUMBER_DIGITS-1:0] line_bcd = {{(4*NUMBER_DIGITS-4){1'b0}}, 4'd1};
    logic line_open = 1'b1;
    logic [1:0] blank_run = 2'd0;

    int idle_pct = IDLE_PCT;
    int errors = 0;
    int quiet_cycles = 0;
    int stall_left = 0;
    logic stall_armed = 1'b0;
    logic stall_done = 1'b0;

    text_stream_line_formatter_core #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        if (errors < MAX_SHOWN)
        begin
            $display("mismatch: %s", msg);
        end
        errors++;
    endtask

    // right-aligned line number and tab, then advance the saturating bcd count
    task automatic put_number();
        logic seen;
        logic all_nine;
        logic carry;
        logic [3:0] d;
        seen = 1'b0;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--)
        begin
            d = line_bcd[4*i +: 4];
            if (d != 4'd0 || i == 0)
            begin
                seen = 1'b1;
            end
            item_beats.push_back(seen ? tslf_pkg::CHR_ZERO + d : tslf_pkg::CHR_SPACE);
        end
        item_beats.push_back(tslf_pkg::CHR_TAB);
        all_nine = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            if (line_bcd[4*i +: 4] != BCD_NINE)
            begin
                all_nine = 1'b0;
            end
        end
        carry = !all_nine;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            if (carry)
            begin
                if (line_bcd[4*i +: 4] == BCD_NINE)
                begin
                    line_bcd[4*i +: 4] = 4'd0;
                end
                else
                begin
                    line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
    endtask

    // driver and predictor
    always @(posedge clk)
    begin : drive
        text_item_t nxt;
        out_beat_t beat;
        logic [7:0] b;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tslf_pkg::CFG_NUMBER_MODE:   fmt_cfg.number_mode = cfg_data;
                    tslf_pkg::CFG_SQUEEZE_BLANK: fmt_cfg.squeeze_blank = cfg_data[0];
                    tslf_pkg::CFG_SHOW_ENDS:     fmt_cfg.show_ends = cfg_data[0];
                    tslf_pkg::CFG_SHOW_TABS:     fmt_cfg.show_tabs = cfg_data[0];
                    tslf_pkg::CFG_SHOW_NONPRINT: fmt_cfg.show_nonprinting = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                item_beats.delete();
                b = s_tdata;
                if (s_tuser == KIND_FILE)
                begin
                    line_open = 1'b1;
                    blank_run = 2'd0;
                end
                else if (b == tslf_pkg::CHR_NL)
                begin
                    if (line_open && blank_run < tslf_pkg::RUN_MAX)
                    begin
                        blank_run = blank_run + 2'd1;
                    end
                    // squeezed blank lines vanish, number included
                    if (!(line_open && fmt_cfg.squeeze_blank &&
                          blank_run >= tslf_pkg::RUN_MAX))
                    begin
                        if (line_open && fmt_cfg.number_mode == tslf_pkg::NUM_ALL)
                        begin
                            put_number();
                        end
                        if (fmt_cfg.show_ends)
                        begin
                            item_beats.push_back(tslf_pkg::CHR_DOLLAR);
                        end
                        item_beats.push_back(tslf_pkg::CHR_NL);
                        line_open = 1'b1;
                    end
                end
                else
                begin
                    if (line_open && (fmt_cfg.number_mode == tslf_pkg::NUM_ALL ||
                                      fmt_cfg.number_mode == tslf_pkg::NUM_NONBLANK))
                    begin
                        put_number();
                    end
                    if ((b == tslf_pkg::CHR_TAB && fmt_cfg.show_tabs) ||
                        (fmt_cfg.show_nonprinting &&
                         (b <= tslf_pkg::CTL_LOW_MAX ||
                          (b >= tslf_pkg::CTL_HIGH_MIN && b <= tslf_pkg::CTL_HIGH_MAX) ||
                          b == tslf_pkg::CHR_DEL)))
                    begin
                        item_beats.push_back(tslf_pkg::CHR_CARET);
                        item_beats.push_back(b == tslf_pkg::CHR_DEL ? tslf_pkg::CHR_QMARK
                                             : b + tslf_pkg::CARET_OFFSET);
                    end
                    else
                    begin
                        item_beats.push_back(b);
                    end
                    line_open = 1'b0;
                    blank_run = 2'd0;
                end
                for (int k = 0; k < item_beats.size(); k++)
                begin
                    beat.out_byte = item_beats[k];
                    beat.last = (k == item_beats.size() - 1);
                    want_out.push_back(beat);
                end
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_in.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    nxt = pending_in.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= nxt.kind;
                    s_tdata <= nxt.byte_value;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and sink
    always @(posedge clk)
    begin : watch
        out_beat_t exp_beat;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (want_out.size() == 0)
                begin
                    flag_error($sformatf("unexpected transaction byte %h last %b",
                                         m_tdata, m_tlast));
                end
                else
                begin
                    exp_beat = want_out.pop_front();
                    if (m_tdata !== exp_beat.out_byte || m_tlast !== exp_beat.last)
                    begin
                        flag_error($sformatf("expected byte %h last %b, got byte %h last %b",
                                             exp_beat.out_byte, exp_beat.last,
                                             m_tdata, m_tlast));
                    end
                end
            end
            if (stall_armed && !stall_done)
            begin
                stall_left = SINK_HOLD;
                stall_done = 1'b1;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_item(input logic kind, input logic [7:0] b);
        text_item_t it;
        it.kind = kind;
        it.byte_value = b;
        pending_in.push_back(it);
    endtask

    task automatic write_reg(input logic [tslf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tslf_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    // unused upper data bit of the one-bit registers is randomized
    task automatic load_format(input logic [1:0] mode, input logic sq, input logic ends,
                               input logic tabs, input logic np);
        write_reg(tslf_pkg::CFG_NUMBER_MODE, mode);
        write_reg(tslf_pkg::CFG_SQUEEZE_BLANK, {1'($urandom_range(1)), sq});
        write_reg(tslf_pkg::CFG_SHOW_ENDS, {1'($urandom_range(1)), ends});
        write_reg(tslf_pkg::CFG_SHOW_TABS, {1'($urandom_range(1)), tabs});
        write_reg(tslf_pkg::CFG_SHOW_NONPRINT, {1'($urandom_range(1)), np});
    endtask

    // text with blank-line runs, tabs, control and high bytes, and file starts
    task automatic queue_text(input int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 3)
                add_item(KIND_FILE, 8'($urandom_range(255)));
            else if (r < 28)
                add_item(KIND_DATA, tslf_pkg::CHR_NL);
            else if (r < 33)
                add_item(KIND_DATA, tslf_pkg::CHR_TAB);
            else if (r < 43)
                add_item(KIND_DATA, 8'($urandom_range(31)));
            else if (r < 46)
                add_item(KIND_DATA, tslf_pkg::CHR_DEL);
            else if (r < 58)
                add_item(KIND_DATA, 8'($urandom_range(255, 128)));
            else
                add_item(KIND_DATA, 8'($urandom_range(126, 32)));
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_in.size() != 0 || s_tvalid || want_out.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset format: plain pass-through
        add_item(KIND_DATA, 8'h41);
        add_item(KIND_DATA, 8'h00);
        add_item(KIND_DATA, 8'hFF);
        add_item(KIND_DATA, 8'h80);
        add_item(KIND_DATA, tslf_pkg::CHR_TAB);
        add_item(KIND_DATA, tslf_pkg::CHR_DEL);
        add_item(KIND_DATA, tslf_pkg::CHR_NL);
        add_item(KIND_DATA, tslf_pkg::CHR_NL);
        wait_idle();

        load_format(tslf_pkg::NUM_ALL, 1'b1, 1'b1, 1'b1, 1'b1);
        write_reg(CFG_IDX_UNUSED, 2'd3);
        add_item(KIND_FILE, 8'hFF);
        add_item(KIND_DATA, tslf_pkg::CHR_NL);
        add_item(KIND_DATA, tslf_pkg::CHR_NL);
        add_item(KIND_DATA, tslf_pkg::CHR_NL);
        add_item(KIND_DATA, 8'h78);
        add_item(KIND_DATA, 8'h00);
        add_item(KIND_DATA, 8'h1F);
        add_item(KIND_DATA, tslf_pkg::CHR_DEL);
        add_item(KIND_DATA, 8'h08);
        add_item(KIND_DATA, 8'h0B);
        add_item(KIND_DATA, tslf_pkg::CHR_TAB);
        add_item(KIND_DATA, 8'hFF);
        add_item(KIND_DATA, tslf_pkg::CHR_NL);
        add_item(KIND_FILE, 8'h00);
        add_item(KIND_DATA, tslf_pkg::CHR_NL);
        wait_idle();

        load_format(tslf_pkg::NUM_ALL, 1'b1, 1'b1, 1'b1, 1'b1);
        queue_text(PHASE_ITEMS);
        wait_idle();

        load_format(tslf_pkg::NUM_NONBLANK, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_text(PHASE_ITEMS);
        wait_idle();

        load_format(NUM_UNUSED, 1'($urandom_range(1)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        queue_text(PHASE_ITEMS);
        wait_idle();

        // no idling on either side
        idle_pct = 0;
        load_format(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        queue_text(PHASE_ITEMS);
        wait_idle();
        idle_pct = IDLE_PCT;

        // long sink hold while the source keeps offering
        load_format(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        queue_text(PHASE_ITEMS);
        stall_armed = 1'b1;
        wait_idle();

        if (want_out.size() != 0)
        begin
            flag_error($sformatf("%0d expected transactions never arrived", want_out.size()));
        end
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
